// ===== hw/rtl/sfd_pkg.sv =====
// ---------------------------------------------------------------------------
// sfd_pkg
// Shared types, codes and CRC-8 functions for the salted CRC-8 frame decoder.
// ---------------------------------------------------------------------------
package sfd_pkg;

   // Payload limit per frame and width of the payload byte counter
   localparam int MAX_PAYLOAD = 32;
   localparam int TAKEN_W     = 6;

   // Depth of the queue between the frame parser and the result stage
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // CRC-8 DVB-S2 polynomial
   localparam logic [7:0] CRC_POLY = 8'hD5;

   // Configuration register indexes
   localparam logic [1:0] REG_BIND_KEY   = 2'd0;
   localparam logic [1:0] REG_LEN_LOW    = 2'd1;
   localparam logic [1:0] REG_LEN_HIGH   = 2'd2;

   // Parser phases
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_CRC     = 2'd2;

   // Queue entry operations
   localparam logic OP_PAYLOAD = 1'b0;
   localparam logic OP_CHECK   = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;

   // One queued item from the parser to the result stage
   typedef struct packed {
      logic       op;
      logic [7:0] data;
      logic [7:0] crc;
      logic [4:0] index;
      logic [3:0] ftype;
      logic [3:0] chan;
      logic [7:0] length;
   } sfd_cmd_type;

   // Queue status toward the parser and the result stage
   typedef struct packed {
      logic full;
      logic empty;
   } sfd_qstat_type;

   // Feed one byte into the CRC, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // CRC of the four bind-key bytes from zero, byte 0 first
   function automatic logic [7:0] crc8_salt(input logic [31:0] key);
      logic [7:0] c;
      c = 8'h00;
      for (int k = 0; k < 4; k++) begin
         c = crc8_byte(c, key[k*8 +: 8]);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/salted_crc8_frame_decoder_top.sv =====
// ---------------------------------------------------------------------------
// salted_crc8_frame_decoder_top
// Salted CRC-8 (poly 0xD5) frame decoder: header, payload bytes, CRC byte.
// ---------------------------------------------------------------------------
// The decoder takes one received byte per cycle while the queue has room. A
// header byte seeds the CRC with the bind-key bytes and gives no result; each
// payload byte comes out as a payload result, and the byte after the payload
// comes out as a good or bad CRC status. A payload byte past the 32-byte limit
// is dropped and the decoder goes back to looking for a header. Sustained rate
// is one byte per cycle while results are taken: the parser updates its CRC
// with one byte of XOR logic per cycle, and a two-entry queue plus the output
// register keep it taking bytes while a result waits, until the queue fills.
// With nothing queued ahead, a byte's command is written into the queue, then
// loaded into the output register, where rsp_valid rises. The configuration
// port always accepts; write registers only while no frame is in flight.
// ---------------------------------------------------------------------------
module salted_crc8_frame_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [4:0]  rsp_byte_index,
   output logic [3:0]  rsp_frame_type,
   output logic [3:0]  rsp_radio_channel,
   output logic [7:0]  rsp_frame_length
);

   sfd_pkg::sfd_cmd_type   front_cmd;
   sfd_pkg::sfd_cmd_type   q_head;
   sfd_pkg::sfd_qstat_type q_stat;
   logic                   front_push;
   logic                   q_pop;
   logic                   take;

   assign csr_ready = 1'b1;
   assign req_ready = !q_stat.full;
   assign take      = req_valid && req_ready;

   sfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .push      (front_push),
      .cmd       (front_cmd)
   );

   sfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .stat     (q_stat)
   );

   sfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (!q_stat.empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_radio_channel (rsp_radio_channel),
      .rsp_frame_length  (rsp_frame_length)
   );

`ifndef NO_ASSERTIONS
   // The parser never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !q_stat.full)
      else $error("frame parser pushed into a full queue");

   // A pop of the queue shows up as a valid result in the next cycle
   a_pop_to_rsp: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid)
      else $error("popped item did not reach the output register");

   // Channel is reported only with a good CRC status
   a_chan_good_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != sfd_pkg::KIND_GOOD) |-> rsp_radio_channel == 4'd0)
      else $error("radio channel reported outside a good frame");

   // Status results carry a zero byte index
   a_status_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != sfd_pkg::KIND_PAYLOAD) |-> rsp_byte_index == 5'd0)
      else $error("status result with nonzero byte index");
`endif

endmodule

// ===== hw/rtl/sfd_front.sv =====
// ---------------------------------------------------------------------------
// sfd_front
// Frame parser: holds the configuration, tracks header, payload and CRC
// phases, runs the CRC and queues one command for each byte that has a result.
// ---------------------------------------------------------------------------
module sfd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   output logic                 push,
   output sfd_pkg::sfd_cmd_type cmd
);

   logic [7:0]                  salt_crc_ff, salt_crc_in;
   logic [127:0]                len_table_ff, len_table_in;
   logic [1:0]                  phase_ff, phase_in;
   logic [7:0]                  crc_ff, crc_in;
   logic [sfd_pkg::TAKEN_W-1:0] taken_ff, taken_in;
   logic [sfd_pkg::TAKEN_W-1:0] taken_next;
   logic [7:0]                  len_ff, len_in;
   logic [3:0]                  type_ff, type_in;
   logic [3:0]                  chan_ff, chan_in;
   logic [7:0]                  hdr_len;

   // Write configuration; keep only the CRC of the bind key
   always_comb begin
      salt_crc_in  = salt_crc_ff;
      len_table_in = len_table_ff;
      if (csr_write) begin
         unique case (csr_index)
            sfd_pkg::REG_BIND_KEY: salt_crc_in = sfd_pkg::crc8_salt(csr_wdata[31:0]);
            sfd_pkg::REG_LEN_LOW:  len_table_in[63:0]   = csr_wdata;
            sfd_pkg::REG_LEN_HIGH: len_table_in[127:64] = csr_wdata;
            default: ;
         endcase
      end
   end

   // Look up the payload length of the header's frame type
   assign hdr_len    = len_table_ff[{rx_byte[7:4], 3'b000} +: 8];
   assign taken_next = taken_ff + sfd_pkg::TAKEN_W'(1);

   // Advance the frame phase and build the queued command
   always_comb begin
      phase_in   = phase_ff;
      crc_in     = crc_ff;
      taken_in   = taken_ff;
      len_in     = len_ff;
      type_in    = type_ff;
      chan_in    = chan_ff;
      push       = 1'b0;
      cmd.op     = sfd_pkg::OP_PAYLOAD;
      cmd.data   = rx_byte;
      cmd.crc    = crc_ff;
      cmd.index  = taken_ff[4:0];
      cmd.ftype  = type_ff;
      cmd.chan   = chan_ff;
      cmd.length = len_ff;
      if (take) begin
         unique case (phase_ff)
            sfd_pkg::PH_PAYLOAD: begin
               if (taken_ff >= sfd_pkg::TAKEN_W'(sfd_pkg::MAX_PAYLOAD)) begin
                  // Drop the overflowing byte
                  phase_in = sfd_pkg::PH_IDLE;
               end else begin
                  push     = 1'b1;
                  crc_in   = sfd_pkg::crc8_byte(crc_ff, rx_byte);
                  taken_in = taken_next;
                  if ({2'b00, taken_next} == len_ff) begin
                     phase_in = sfd_pkg::PH_CRC;
                  end
               end
            end
            sfd_pkg::PH_CRC: begin
               push      = 1'b1;
               cmd.op    = sfd_pkg::OP_CHECK;
               cmd.index = 5'd0;
               phase_in  = sfd_pkg::PH_IDLE;
            end
            default: begin
               // Header byte, also taken in the unused phase code
               crc_in   = sfd_pkg::crc8_byte(salt_crc_ff, rx_byte);
               type_in  = rx_byte[7:4];
               chan_in  = rx_byte[3:0];
               len_in   = hdr_len;
               taken_in = '0;
               phase_in = (hdr_len == 8'd0) ? sfd_pkg::PH_CRC : sfd_pkg::PH_PAYLOAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         salt_crc_ff  <= '0;
         len_table_ff <= '0;
         phase_ff     <= sfd_pkg::PH_IDLE;
         crc_ff       <= '0;
         taken_ff     <= '0;
         len_ff       <= '0;
         type_ff      <= '0;
         chan_ff      <= '0;
      end else begin
         salt_crc_ff  <= salt_crc_in;
         len_table_ff <= len_table_in;
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         taken_ff     <= taken_in;
         len_ff       <= len_in;
         type_ff      <= type_in;
         chan_ff      <= chan_in;
      end
   end

endmodule

// ===== hw/rtl/sfd_queue.sv =====
// ---------------------------------------------------------------------------
// sfd_queue
// Short command queue between the frame parser and the result stage.
// ---------------------------------------------------------------------------
module sfd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sfd_pkg::sfd_cmd_type  push_cmd,
   input  logic                  pop,
   output sfd_pkg::sfd_cmd_type  head,
   output sfd_pkg::sfd_qstat_type stat
);

   sfd_pkg::sfd_cmd_type       entry_ff [sfd_pkg::QUEUE_DEPTH];
   logic [sfd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sfd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sfd_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign stat.full  = (count_ff == sfd_pkg::QCNT_W'(sfd_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sfd_pkg::QPTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + sfd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sfd_pkg::QPTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + sfd_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + sfd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - sfd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/sfd_back.sv =====
// ---------------------------------------------------------------------------
// sfd_back
// Result stage: checks the CRC of frame-end commands, formats the result and
// holds it in the output register until it is taken.
// ---------------------------------------------------------------------------
module sfd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  sfd_pkg::sfd_cmd_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_data_byte,
   output logic [4:0]           rsp_byte_index,
   output logic [3:0]           rsp_frame_type,
   output logic [3:0]           rsp_radio_channel,
   output logic [7:0]           rsp_frame_length
);

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] data_ff;
   logic [4:0] index_ff;
   logic [3:0] type_ff;
   logic [3:0] chan_ff, chan_in;
   logic [7:0] len_ff;
   logic       good;

   // Load a new item when the output register is empty or being taken
   assign q_pop = q_valid && (!valid_ff || rsp_ready);
   assign good  = (q_head.crc == q_head.data);

   // Classify the queued command
   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
      unique case (q_head.op)
         sfd_pkg::OP_CHECK: begin
            kind_in = good ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD;
            chan_in = good ? q_head.chan : 4'd0;
         end
         default: begin
            kind_in = sfd_pkg::KIND_PAYLOAD;
            chan_in = 4'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff  <= kind_in;
         data_ff  <= q_head.data;
         index_ff <= q_head.index;
         type_ff  <= q_head.ftype;
         chan_ff  <= chan_in;
         len_ff   <= q_head.length;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_byte_index    = index_ff;
   assign rsp_frame_type    = type_ff;
   assign rsp_radio_channel = chan_ff;
   assign rsp_frame_length  = len_ff;

endmodule

// ===== tb/tb_salted_crc8_frame_decoder_top.sv =====
// ---------------------------------------------------------------------------
// tb_salted_crc8_frame_decoder_top
// Self-checking testbench for the salted CRC-8 frame decoder.
// ---------------------------------------------------------------------------
// A short table of directed bytes and register writes runs first: reset
// state, zero-length frames, good and bad CRC bytes, byte extremes and a
// write to the unused register index. Random phases follow, each with its
// own bind key and length tables (zero, all ones, lengths at and beyond the
// payload limit). Every accepted byte runs through a local frame decoder
// model, and each accepted result is compared field by field against the
// oldest pending expectation. Both channels idle in random bursts; one phase
// holds off the result channel for a long stretch, another pauses the sender
// until all results are back, and the calm and last phases run without idling.
// ---------------------------------------------------------------------------
module tb_salted_crc8_frame_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Register index with no register behind it
   localparam logic [1:0] REG_SPARE = 2'd3;

   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_CYCLES     = 300;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int NUM_PHASES      = 6;
   localparam int PHASE_CALM      = 1;
   localparam int PHASE_HOLD      = 2;
   localparam int PHASE_PAUSE     = 3;
   localparam int PHASE_OVERFLOW  = 4;
   localparam int CYCLE_LIMIT     = 200000;

   // One decoded result as seen on the result channel
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [4:0] byte_index;
      logic [3:0] frame_type;
      logic [3:0] radio_channel;
      logic [7:0] frame_length;
   } decoded_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_REG} row_kind_type;
   typedef enum logic [1:0] {FILL_NONE, FILL_GOOD, FILL_BAD} crc_fill_type;

   // One row of the directed stimulus
   typedef struct packed {
      row_kind_type what;
      crc_fill_type fill;
      logic [7:0]   rx;
      logic [1:0]   reg_index;
      logic [63:0]  reg_value;
      bit           typed;
      decoded_type  want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = sfd_pkg::REG_BIND_KEY;
   logic [63:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [4:0]  rsp_byte_index;
   logic [3:0]  rsp_frame_type;
   logic [3:0]  rsp_radio_channel;
   logic [7:0]  rsp_frame_length;

   // Local copy of the decoder state and its registers
   logic [1:0]  dec_phase = sfd_pkg::PH_IDLE;
   logic [7:0]  dec_crc = '0;
   logic [5:0]  dec_taken = '0;
   logic [7:0]  dec_len = '0;
   logic [3:0]  dec_type = '0;
   logic [3:0]  dec_chan = '0;
   logic [31:0] cfg_bind_key = '0;
   logic [63:0] cfg_len_low = '0;
   logic [63:0] cfg_len_high = '0;

   decoded_type  expected_results[$];
   decoded_type  front_result;
   plan_row_type plan[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   bit           gaps_on = 1'b1;
   bit           stalls_on = 1'b1;
   bit           hold_rsp = 1'b0;
   int           hold_left = 0;
   int           stall_left = 0;

   salted_crc8_frame_decoder_top uut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_radio_channel (rsp_radio_channel),
      .rsp_frame_length  (rsp_frame_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // CRC-8 update, MSB first, no final xor
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ sfd_pkg::CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // Payload length that the current tables give for a frame type
   function automatic logic [7:0] frame_len_of(input logic [3:0] ftype);
      return ftype[3] ? cfg_len_high[ftype[2:0]*8 +: 8] : cfg_len_low[ftype[2:0]*8 +: 8];
   endfunction

   // Advance the local decoder by one accepted byte
   task automatic advance_decoder(input logic [7:0] b, output bit produced,
                                  output bit dropped, output decoded_type r);
      r = '0;
      produced = 1'b0;
      dropped = 1'b0;
      case (dec_phase)
         sfd_pkg::PH_PAYLOAD: begin
            if (dec_taken >= sfd_pkg::MAX_PAYLOAD) begin
               // past the payload limit: drop and look for a header again
               dec_phase = sfd_pkg::PH_IDLE;
               dropped = 1'b1;
            end else begin
               dec_crc = crc_update(dec_crc, b);
               r.kind = sfd_pkg::KIND_PAYLOAD;
               r.data_byte = b;
               r.byte_index = dec_taken[4:0];
               r.frame_type = dec_type;
               r.frame_length = dec_len;
               produced = 1'b1;
               dec_taken = dec_taken + 6'd1;
               if ({2'b00, dec_taken} == dec_len) begin
                  dec_phase = sfd_pkg::PH_CRC;
               end
            end
         end
         sfd_pkg::PH_CRC: begin
            r.kind = (dec_crc == b) ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD;
            r.data_byte = b;
            r.frame_type = dec_type;
            r.radio_channel = (dec_crc == b) ? dec_chan : 4'h0;
            r.frame_length = dec_len;
            produced = 1'b1;
            dec_phase = sfd_pkg::PH_IDLE;
         end
         default: begin
            // header: salt with the bind key, then feed the header itself
            dec_crc = '0;
            for (int k = 0; k < 4; k++) begin
               dec_crc = crc_update(dec_crc, cfg_bind_key[k*8 +: 8]);
            end
            dec_crc = crc_update(dec_crc, b);
            dec_type = b[7:4];
            dec_chan = b[3:0];
            dec_len = frame_len_of(b[7:4]);
            dec_taken = '0;
            dec_phase = (dec_len == 8'd0) ? sfd_pkg::PH_CRC : sfd_pkg::PH_PAYLOAD;
         end
      endcase
   endtask

   // Offer one byte, wait for acceptance, then record what it should cause
   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input decoded_type typed_want, output bit counted);
      bit produced;
      bit dropped;
      decoded_type predicted;
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      advance_decoder(b, produced, dropped, predicted);
      if (produced) begin
         expected_results.push_back(typed ? typed_want : predicted);
      end
      counted = !dropped;
   endtask

   task automatic sender_idle(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stop sending, wait for every pending result, then let the pipe settle
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         sfd_pkg::REG_BIND_KEY: cfg_bind_key = value[31:0];
         sfd_pkg::REG_LEN_LOW:  cfg_len_low = value;
         sfd_pkg::REG_LEN_HIGH: cfg_len_high = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly short lengths, a few near, at or past the payload limit
   function automatic logic [63:0] random_lengths();
      logic [63:0] t;
      int r;
      t = '0;
      for (int i = 0; i < 8; i++) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            case ($urandom_range(0, 4))
               0: t[i*8 +: 8] = 8'd31;
               1: t[i*8 +: 8] = 8'd32;
               2: t[i*8 +: 8] = 8'd33;
               3: t[i*8 +: 8] = 8'd63;
               default: t[i*8 +: 8] = 8'd255;
            endcase
         end else if (r < 20) begin
            t[i*8 +: 8] = 8'd0;
         end else begin
            t[i*8 +: 8] = 8'($urandom_range(1, 6));
         end
      end
      return t;
   endfunction

   // Next random byte, shaped by where the decoder is in its frame
   function automatic logic [7:0] next_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (dec_phase == sfd_pkg::PH_CRC) begin
         if ($urandom_range(0, 99) < 65) begin
            b = dec_crc;
         end
      end else if (dec_phase != sfd_pkg::PH_PAYLOAD) begin
         // keep long frames rare
         if (frame_len_of(b[7:4]) > 8'd8 && $urandom_range(0, 3) != 0) begin
            b = 8'($urandom_range(0, 255));
         end
      end
      return b;
   endfunction

   function automatic plan_row_type byte_row(input logic [7:0] rx, input crc_fill_type fill);
      plan_row_type row;
      row = '0;
      row.what = ROW_BYTE;
      row.fill = fill;
      row.rx = rx;
      return row;
   endfunction

   function automatic plan_row_type checked_row(input logic [7:0] rx, input logic [1:0] kind,
                                                input logic [3:0] ftype,
                                                input logic [3:0] chan,
                                                input logic [7:0] len);
      plan_row_type row;
      row = byte_row(rx, FILL_NONE);
      row.typed = 1'b1;
      row.want.kind = kind;
      row.want.data_byte = rx;
      row.want.frame_type = ftype;
      row.want.radio_channel = chan;
      row.want.frame_length = len;
      return row;
   endfunction

   function automatic plan_row_type reg_row(input logic [1:0] index, input logic [63:0] value);
      plan_row_type row;
      row = '0;
      row.what = ROW_REG;
      row.reg_index = index;
      row.reg_value = value;
      return row;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result channel: random stall bursts, plus one long hold on request
   always @(negedge clock) begin
      if (hold_rsp) begin
         hold_left = HOLD_CYCLES;
         hold_rsp = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d, data_byte %0d", rsp_kind, rsp_data_byte);
            mismatch_count++;
         end else begin
            front_result = expected_results.pop_front();
            check_field("kind", front_result.kind, rsp_kind);
            check_field("data_byte", front_result.data_byte, rsp_data_byte);
            check_field("byte_index", front_result.byte_index, rsp_byte_index);
            check_field("frame_type", front_result.frame_type, rsp_frame_type);
            check_field("radio_channel", front_result.radio_channel, rsp_radio_channel);
            check_field("frame_length", front_result.frame_length, rsp_frame_length);
         end
      end
   end

   // Watchdog on the whole run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** salted_crc8_frame_decoder_top: FAILED **");
      $finish;
   end

   initial begin
      logic [7:0]  b;
      logic [31:0] key;
      logic [63:0] len_lo;
      logic [63:0] len_hi;
      bit          counted;
      int          sent;
      int          iter;

      // Right after reset: zero key and tables, so every frame is zero length
      plan.push_back(byte_row(8'h00, FILL_NONE));
      plan.push_back(checked_row(8'h00, sfd_pkg::KIND_GOOD, 4'h0, 4'h0, 8'd0));
      plan.push_back(byte_row(8'hFF, FILL_NONE));
      plan.push_back(checked_row(8'h00, sfd_pkg::KIND_BAD, 4'hF, 4'h0, 8'd0));
      // Full key, short lengths for types 0, 1, 8; unused index must not land
      plan.push_back(reg_row(sfd_pkg::REG_BIND_KEY, 64'hFFFF_FFFF_FFFF_FFFF));
      plan.push_back(reg_row(sfd_pkg::REG_LEN_LOW, 64'h2000_0000_0000_0201));
      plan.push_back(reg_row(sfd_pkg::REG_LEN_HIGH, 64'hFF21_0000_0000_0001));
      plan.push_back(reg_row(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF));
      plan.push_back(byte_row(8'h1A, FILL_NONE));
      plan.push_back(byte_row(8'hFF, FILL_NONE));
      plan.push_back(byte_row(8'h00, FILL_NONE));
      plan.push_back(byte_row(8'h00, FILL_GOOD));
      plan.push_back(byte_row(8'h8F, FILL_NONE));
      plan.push_back(byte_row(8'h5A, FILL_NONE));
      plan.push_back(byte_row(8'h00, FILL_BAD));
      plan.push_back(byte_row(8'h35, FILL_NONE));
      plan.push_back(byte_row(8'h00, FILL_GOOD));
      plan.push_back(byte_row(8'h0C, FILL_NONE));
      plan.push_back(byte_row(8'hFF, FILL_NONE));
      plan.push_back(byte_row(8'h00, FILL_BAD));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (plan[i]) begin
         if (plan[i].what == ROW_REG) begin
            wait_quiet();
            write_reg(plan[i].reg_index, plan[i].reg_value);
         end else begin
            b = plan[i].rx;
            if (plan[i].fill == FILL_GOOD) begin
               b = dec_crc;
            end else if (plan[i].fill == FILL_BAD) begin
               b = ~dec_crc;
            end
            if ($urandom_range(0, 5) == 0) begin
               sender_idle($urandom_range(1, 18));
            end
            send_byte(b, plan[i].typed, plan[i].want, counted);
         end
      end

      // Random phases, each with fresh registers
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_quiet();
         gaps_on = (p != PHASE_CALM) && (p != NUM_PHASES - 1);
         stalls_on = gaps_on;
         key = $urandom;
         len_lo = random_lengths();
         len_hi = random_lengths();
         if (p == 0) begin
            // zero key; lengths at the limit, one past it, and the maximum
            key = '0;
            len_hi[63:40] = {8'd255, 8'd33, 8'd32};
         end else if (p == PHASE_CALM) begin
            key = '1;
            len_lo = '0;
         end else if (p == PHASE_OVERFLOW) begin
            len_lo = '1;
         end
         write_reg(sfd_pkg::REG_BIND_KEY, {$urandom, key});
         write_reg(sfd_pkg::REG_LEN_LOW, len_lo);
         write_reg(sfd_pkg::REG_LEN_HIGH, len_hi);

         sent = 0;
         iter = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (p == PHASE_HOLD && iter == 20) begin
               hold_rsp = 1'b1;
            end
            if (p == PHASE_PAUSE && iter == ITEMS_PER_PHASE / 2) begin
               wait_quiet();
            end
            if (gaps_on && $urandom_range(0, 5) == 0) begin
               sender_idle($urandom_range(1, 18));
            end
            send_byte(next_byte(), 1'b0, '0, counted);
            sent += counted;
            iter++;
         end
         // finish the frame in flight before touching the registers
         while (dec_phase != sfd_pkg::PH_IDLE) begin
            send_byte(next_byte(), 1'b0, '0, counted);
         end
      end

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("** salted_crc8_frame_decoder_top: PASSED **");
      end else begin
         $display("** salted_crc8_frame_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_front.sv
hw/rtl/sfd_queue.sv
hw/rtl/sfd_back.sv
hw/rtl/salted_crc8_frame_decoder_top.sv
tb/tb_salted_crc8_frame_decoder_top.sv
